[rtl/rdsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter package
// Shared types, constants and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int unsigned RADIX_W   = 5;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CHAR_W    = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [DIGIT_W-1:0] LARGEST_DECIMAL_DIGIT = 4'd9;
    localparam logic [DIGIT_W-1:0] FIRST_LETTER_VALUE    = 4'd10;
    localparam logic [DIGIT_W-1:0] LARGEST_DIGIT         = 4'd15;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_LOAD = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] m;
        logic [CHAR_W-1:0]  res;
        m = d & LARGEST_DIGIT;
        if (m <= LARGEST_DECIMAL_DIGIT) begin
            res = ASCII_ZERO + {3'b000, m};
        end else begin
            res = ASCII_A + {3'b000, 4'(m - FIRST_LETTER_VALUE)};
        end
        return res;
    endfunction

endpackage

[rtl/rdsc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdsc_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/radix_digit_string_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter core
// Converts a non-negative integer to its ASCII digit string in radix 2..16.
// ----------------------------------------------------------------------------
// Usage:
// The radix register is written through i_cfg_we and i_cfg_wdata while the
// block is idle; values below 2 act as 2 and values above 16 act as 16.
// An input item is taken when i_valid and o_ready are both high. The block
// then divides the value by the radix with one shared restoring divider,
// one quotient bit per cycle. Digits go to a small RAM least significant
// first and are replayed most significant first on the output channel, one
// result item per digit, the last one flagged by o_last_digit. Each result
// passes through a RAM read, a load into the output register and a wait for
// the receiver.
// o_ready is high only while the block is idle. When the receiver stalls,
// the result stays in the output register unchanged until taken.
// Reset returns the radix to 10, drops any item in flight and clears o_valid.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_core
    import rdsc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 31,
    parameter int unsigned MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_W-1:0]    i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last_digit
);

    localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
    localparam int unsigned BIT_W = $clog2(VALUE_BITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    r_div, n_div;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    logic [RADIX_W-1:0]    w_trial;
    logic                  w_ge;
    logic [DIGIT_W-1:0]    w_rem_nx;
    logic [VALUE_BITS-1:0] w_quo_nx;
    logic                  w_ram_we;
    logic [DIGIT_W-1:0]    w_ram_rdata;

    assign w_trial  = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge     = (w_trial >= r_div);
    assign w_rem_nx = w_ge ? DIGIT_W'(w_trial - r_div) : w_trial[DIGIT_W-1:0];
    assign w_quo_nx = {r_quo[VALUE_BITS-2:0], w_ge};

    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        w_ram_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_div   = eff_radix(r_radix);
                    n_quo   = i_value;
                    n_rem   = '0;
                    n_bit   = BIT_LAST;
                    n_idx   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = w_quo_nx;
                n_rem = w_rem_nx;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    w_ram_we = 1'b1;
                    n_rem    = '0;
                    n_bit    = BIT_LAST;
                    if ((w_quo_nx == '0) || (r_idx == IDX_LAST)) begin
                        n_state = S_READ;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_char      = ascii_of(w_ram_rdata);
                n_last      = (r_idx == '0);
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    rdsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_rem_nx),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_character  = r_char;
    assign o_last_digit = r_last;

endmodule

[rtl/rdsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter checker
// Port-level assertions on the converter core, attached by bind.
// ----------------------------------------------------------------------------
module rdsc_checker
    import rdsc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last_digit
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last_digit))
        else $error("Result item changed while stalled.");

    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("Result item shown while the block is idle.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Block still ready after taking an item.");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character >= 7'd48 && o_character <= 7'd57) ||
                    (o_character >= 7'd65 && o_character <= 7'd70))
        else $error("Result character is not a digit.");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_digit |=> o_ready && !o_valid)
        else $error("Block not idle after the last character.");

endmodule

bind radix_digit_string_converter_core rdsc_checker u_rdsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_character  (o_character),
    .o_last_digit (o_last_digit)
);
